### hdl/fdd_pkg.sv
// ----------------------------------------------------------------------------
// fdd_pkg
// Shared types and codes for the flip-dot row refresh controller.
// ----------------------------------------------------------------------------
package fdd_pkg;

	// operation codes of an input request
	localparam logic [2:0] OP_SET_DOT = 3'd0;
	localparam logic [2:0] OP_FILL    = 3'd1;
	localparam logic [2:0] OP_REFRESH = 3'd2;
	localparam logic [2:0] OP_BLANK   = 3'd3;
	localparam logic [2:0] OP_FLIP    = 3'd4;

	// controls from the sequencer to the bitmap store
	typedef struct packed {
		logic rd_en;
		logic tgt_we;
		logic act_we;
		logic fill;
		logic fill_value;
	} mem_ctl_t;

endpackage

### hdl/fdd_store.sv
// ----------------------------------------------------------------------------
// fdd_store
// Target and actual bitmaps, one row per entry, with per-row valid bits.
// ----------------------------------------------------------------------------
module fdd_store #(
	parameter int ROWS = 16,
	parameter int COLS = 32,
	parameter int RW   = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fdd_pkg::mem_ctl_t ctl,
	input  logic [RW-1:0]    rd_row,
	input  logic [RW-1:0]    wr_row,
	input  logic [COLS-1:0]  tgt_wdata,
	input  logic [COLS-1:0]  act_wdata,
	output logic [COLS-1:0]  tgt_rdata,
	output logic [COLS-1:0]  act_rdata
);
	import fdd_pkg::*;

	logic [COLS-1:0] tgt_mem [ROWS];
	logic [COLS-1:0] act_mem [ROWS];
	logic [ROWS-1:0] tgt_vld_q;
	logic [ROWS-1:0] act_vld_q;
	logic            fill_q;
	logic [COLS-1:0] tgt_rd_q;
	logic [COLS-1:0] act_rd_q;
	logic            tgt_rv_q;
	logic            act_rv_q;

	always_ff @(posedge clk) begin
		if (ctl.tgt_we) begin
			tgt_mem[wr_row] <= tgt_wdata;
		end
		if (ctl.act_we) begin
			act_mem[wr_row] <= act_wdata;
		end
		if (ctl.rd_en) begin
			tgt_rd_q <= tgt_mem[rd_row];
			act_rd_q <= act_mem[rd_row];
			tgt_rv_q <= tgt_vld_q[rd_row];
			act_rv_q <= act_vld_q[rd_row];
		end
	end

	// target rows unwritten since reset or fill read as fill_q, actual as 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_vld_q <= '0;
			act_vld_q <= '0;
			fill_q    <= 1'b0;
		end else begin
			if (ctl.fill) begin
				tgt_vld_q <= '0;
				fill_q    <= ctl.fill_value;
			end else if (ctl.tgt_we) begin
				tgt_vld_q[wr_row] <= 1'b1;
			end
			if (ctl.act_we) begin
				act_vld_q[wr_row] <= 1'b1;
			end
		end
	end

	assign tgt_rdata = tgt_rv_q ? tgt_rd_q : {COLS{fill_q}};
	assign act_rdata = act_rv_q ? act_rd_q : '0;

endmodule

### hdl/flip_dot_diff_refresh.sv
// ----------------------------------------------------------------------------
// flip_dot_diff_refresh
// Flip-dot controller: target/actual bitmaps and a per-row flip scanner.
// ----------------------------------------------------------------------------
// Usage: an input request (operation, row, column, dot_value) is taken on
// in_valid && in_ready. Set dot, fill and unused codes give no flips. Refresh
// row sends one flip for every dot whose target differs from the actual state,
// lowest column first, and copies the target row into actual. Blank row sends
// an off flip for every column. Immediate flip sends one flip and updates
// actual. The final flip of a request carries last_flip.
// Timing: an accepted request is registered while the bitmap store reads its
// row, and the sequencer acts on that row in ST_EXEC; then the column scanner
// walks the row one column a cycle while no stall on out_ready holds it, up
// to the highest column that still has a flip pending. in_ready is high only
// while the sequencer is idle.
// Results sit in an output register; a stall on out_ready holds the scanner
// at its next pending column and keeps the flip stable. The next request can be
// taken while the final flip still waits there.
// Reset clears both bitmaps at once through per-row valid bits; no sweep.
// ----------------------------------------------------------------------------
module flip_dot_diff_refresh #(
	parameter int ROWS = 16,
	parameter int COLS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] operation,
	input  logic [3:0] row,
	input  logic [4:0] column,
	input  logic       dot_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] flip_row,
	output logic [4:0] flip_column,
	output logic       flip_value,
	output logic       last_flip
);
	import fdd_pkg::*;

	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_SCAN = 3'b100
	} state_t;

	state_t          state_q;
	logic [2:0]      op_q;
	logic [3:0]      row_q;
	logic [4:0]      col_q;
	logic            val_q;
	logic [COLS-1:0] pending_q;
	logic [COLS-1:0] line_q;
	logic [CW-1:0]   col_cnt_q;
	logic            out_valid_q;
	logic [3:0]      flip_row_q;
	logic [4:0]      flip_column_q;
	logic            flip_value_q;
	logic            last_flip_q;

	mem_ctl_t        ctl;
	logic [RW-1:0]   rd_row;
	logic [RW-1:0]   wr_row;
	logic [COLS-1:0] tgt_wdata;
	logic [COLS-1:0] act_wdata;
	logic [COLS-1:0] tgt_rdata;
	logic [COLS-1:0] act_rdata;

	logic            accept;
	logic            row_ok;
	logic            col_ok;
	logic            in_row_ok;
	logic [COLS-1:0] dot_mask;
	logic [COLS-1:0] cur_mask;
	logic [COLS-1:0] pend_rest;
	logic            slot_free;
	logic            emit;
	logic            advance;

	fdd_store #(
		.ROWS(ROWS),
		.COLS(COLS),
		.RW  (RW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rd_row   (rd_row),
		.wr_row   (wr_row),
		.tgt_wdata(tgt_wdata),
		.act_wdata(act_wdata),
		.tgt_rdata(tgt_rdata),
		.act_rdata(act_rdata)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign in_row_ok = 7'(row) < 7'(ROWS);
	assign row_ok    = 7'(row_q) < 7'(ROWS);
	assign col_ok    = 7'(col_q) < 7'(COLS);
	assign dot_mask  = COLS'(1) << col_q;
	assign cur_mask  = COLS'(1) << col_cnt_q;
	assign pend_rest = pending_q & ~cur_mask;
	assign slot_free = !out_valid_q || out_ready;
	assign emit      = (state_q == ST_SCAN) && pending_q[col_cnt_q] && slot_free;
	assign advance   = (state_q == ST_SCAN) && (!pending_q[col_cnt_q] || slot_free);

	assign rd_row = RW'(row);
	assign wr_row = RW'(row_q);

	always_comb begin
		ctl            = '0;
		ctl.rd_en      = accept && in_row_ok;
		ctl.fill_value = val_q;
		tgt_wdata      = val_q ? (tgt_rdata | dot_mask) : (tgt_rdata & ~dot_mask);
		act_wdata      = val_q ? (act_rdata | dot_mask) : (act_rdata & ~dot_mask);
		if (state_q == ST_EXEC) begin
			unique case (op_q)
				OP_SET_DOT: ctl.tgt_we = row_ok && col_ok;
				OP_FILL:    ctl.fill   = 1'b1;
				OP_REFRESH: begin
					ctl.act_we = row_ok;
					act_wdata  = tgt_rdata;
				end
				OP_FLIP:    ctl.act_we = row_ok && col_ok;
				default:    ctl.act_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_SET_DOT;
			row_q     <= '0;
			col_q     <= '0;
			val_q     <= 1'b0;
			pending_q <= '0;
			line_q    <= '0;
			col_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q    <= operation;
						row_q   <= row;
						col_q   <= column;
						val_q   <= dot_value;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					col_cnt_q <= '0;
					state_q   <= ST_IDLE;
					unique case (op_q)
						OP_REFRESH: begin
							if (row_ok) begin
								pending_q <= tgt_rdata ^ act_rdata;
								line_q    <= tgt_rdata;
								state_q   <= ST_SCAN;
							end
						end
						OP_BLANK: begin
							if (row_ok) begin
								pending_q <= '1;
								line_q    <= '0;
								state_q   <= ST_SCAN;
							end
						end
						OP_FLIP: begin
							if (row_ok && col_ok) begin
								pending_q <= dot_mask;
								line_q    <= {COLS{val_q}};
								state_q   <= ST_SCAN;
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_SCAN: begin
					// the counter stops on the last pending column so it never runs past COLS-1
					if (pending_q == '0) begin
						state_q <= ST_IDLE;
					end else if (advance) begin
						pending_q <= pend_rest;
						if (pend_rest == '0) begin
							state_q <= ST_IDLE;
						end else begin
							col_cnt_q <= col_cnt_q + CW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			flip_row_q    <= row_q;
			flip_column_q <= 5'(col_cnt_q);
			flip_value_q  <= line_q[col_cnt_q];
			last_flip_q   <= (pend_rest == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign flip_row    = flip_row_q;
	assign flip_column = flip_column_q;
	assign flip_value  = flip_value_q;
	assign last_flip   = last_flip_q;

	// no pending flip below the scan column
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ((pending_q & (cur_mask - COLS'(1))) == '0))
		else $error("pending flip left behind the scan column");

	a_last_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (pend_rest == '0)) |=> (state_q == ST_IDLE))
		else $error("scan did not end after the final flip");

	a_empty_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && (pending_q == '0)) |=> (state_q == ST_IDLE))
		else $error("scan with nothing pending did not end");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted request not executed");

endmodule
